FILE: rtl/erjm_pkg.sv
// erjm_pkg: shared constants and types of the event rate / jitter monitor
// used by erjm_div and event_rate_jitter_monitor; no dependencies
`default_nettype none

package erjm_pkg;

  localparam int CHANNELS   = 8;
  localparam int WINDOW_MAX = 64;

  localparam int CH_W    = $clog2(CHANNELS);
  localparam int WIN_W   = $clog2(WINDOW_MAX);
  localparam int FILL_W  = 7;
  localparam int RING_AW = CH_W + WIN_W;
  localparam int RING_DEPTH = CHANNELS * WINDOW_MAX;

  localparam int TS_W   = 32;
  localparam int PER_W  = 24;
  localparam int MEAN_W = 40;
  localparam int M2_W   = 64;
  localparam int CNT_W  = 32;
  localparam int OUT_W  = 32;
  localparam int CFG_W  = 7;

  localparam int DIV_NW = 64;
  localparam int DIV_DW = 41;
  localparam int MUL_W  = 34;

  localparam int TIMEOUT_PERIODS = 10;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STAT_VALID      = 2'd0;
  localparam logic [1:0] STAT_NOT_ENOUGH = 2'd1;
  localparam logic [1:0] STAT_TIMED_OUT  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TS_W-1:0]   last;
    logic [MEAN_W-1:0] mean;
    logic [M2_W-1:0]   m2;
    logic [FILL_W-1:0] fill;
    logic [WIN_W-1:0]  head;
  } ch_state_t;

  localparam int CH_STATE_W = $bits(ch_state_t);

endpackage

`default_nettype wire

FILE: rtl/event_rate_jitter_monitor.sv
// event_rate_jitter_monitor: top level, per-channel sliding-window period statistics
// depends on erjm_pkg, erjm_ram and erjm_div
`default_nettype none

// One item is handled at a time. Channel state sits in an 8-entry ram and the
// recent periods in a 512-entry ring ram, both with a registered read. A tick
// uses the shared radix-2 divide for the mean update and a serial multiply for
// the M2 update; a channel's first tick skips both. A query that reports valid
// statistics uses up to two divides and a 32-step square root; one that
// reports not_enough or timed_out skips them. The result sits in an output
// register, so the next request is taken while it waits. No clearing pass is
// needed after reset.
module event_rate_jitter_monitor import erjm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata,     // window length
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [39:0]  s_axis_tdata,  // channel[2:0], timestamp[34:3], zero fill
  input  wire logic         s_axis_tuser,  // op
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [135:0] m_axis_tdata,  // tick_count, frequency, mean, jitter
  output logic      [1:0]   m_axis_tuser   // status
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_RDST  = 11'b000_0000_0010,
    ST_RDRNG = 11'b000_0000_0100,
    ST_DIV1  = 11'b000_0000_1000,
    ST_MUL   = 11'b000_0001_0000,
    ST_WRB   = 11'b000_0010_0000,
    ST_QVAR  = 11'b000_0100_0000,
    ST_QDIVF = 11'b000_1000_0000,
    ST_QDIVV = 11'b001_0000_0000,
    ST_QSQRT = 11'b010_0000_0000,
    ST_QOUT  = 11'b100_0000_0000
  } state_t;

  localparam int MUL_CW = $clog2(MUL_W + 1);

  state_t state;

  logic [CFG_W-1:0] window;
  logic [CHANNELS-1:0] chan_valid;

  logic              op_r;
  logic [CH_W-1:0]   ch_r;
  logic [TS_W-1:0]   ts_r;
  ch_state_t         cur;
  logic [PER_W-1:0]  per_r;
  logic [PER_W-1:0]  old_r;
  logic              full_r;
  logic              neg_r;
  logic signed [42:0] d_r;
  logic signed [25:0] a_r;
  logic              ring_wr_r;
  logic [RING_AW-1:0] ring_waddr_r;

  logic [2*MUL_W-1:0] mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] acc;
  logic [MUL_CW-1:0]  mul_cnt;
  logic               mneg_r;

  logic [M2_W-1:0] var_r;
  logic [OUT_W-1:0] sq_r;
  logic [63:0]      sq_sq;
  logic [4:0]       sq_bit;

  logic [CNT_W-1:0]  res_count;
  logic [1:0]        res_status;
  logic [OUT_W-1:0]  res_freq;
  logic [MEAN_W-1:0] res_mean;
  logic [OUT_W-1:0]  res_jit;

  logic              div_go;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;

  logic                  accept;
  logic [CH_STATE_W-1:0] st_rdata;
  ch_state_t             st_rd;
  logic                  st_we;
  logic [CH_W-1:0]       st_raddr;
  logic [PER_W-1:0]      ring_rdata;
  logic                  ring_we;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign st_raddr = accept ? s_axis_tdata[CH_W-1:0] : ch_r;
  assign st_we    = (state == ST_WRB);
  assign ring_we  = (state == ST_WRB) && ring_wr_r;

  erjm_ram #(.WIDTH(CH_STATE_W), .DEPTH(CHANNELS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (ch_r),
    .wdata (cur),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  erjm_ram #(.WIDTH(PER_W), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr_r),
    .wdata (per_r),
    .raddr ({ch_r, st_rd.head}),
    .rdata (ring_rdata)
  );

  erjm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // a channel never written reads as its reset value
  assign st_rd = chan_valid[ch_r] ? ch_state_t'(st_rdata) : '0;

  // ---------------- tick arithmetic ----------------
  logic [FILL_W-1:0] w_eff;
  logic [TS_W-1:0]   el_diff;
  logic [PER_W-1:0]  per_calc;
  logic signed [42:0] d_calc;
  logic [42:0]        d_calc_abs;
  logic signed [25:0] a_calc;
  logic [25:0]        a_calc_abs;
  ch_state_t          tick_st;

  always_comb begin
    if (window == '0) begin
      w_eff = FILL_W'(1);
    end else if (window > FILL_W'(WINDOW_MAX)) begin
      w_eff = FILL_W'(WINDOW_MAX);
    end else begin
      w_eff = window;
    end
  end

  assign el_diff  = ts_r - st_rd.last;
  assign per_calc = (el_diff[TS_W-1:PER_W] != '0) ? {PER_W{1'b1}} : el_diff[PER_W-1:0];
  assign d_calc   = $signed({3'b000, per_calc, 16'h0000}) - $signed({3'b000, st_rd.mean});
  assign d_calc_abs = d_calc[42] ? 43'(-d_calc) : 43'(d_calc);
  assign a_calc   = $signed({2'b00, per_r}) - $signed({2'b00, ring_rdata});
  assign a_calc_abs = a_calc[25] ? 26'(-a_calc) : 26'(a_calc);

  // channel state after a tick's time and count update
  always_comb begin
    tick_st      = st_rd;
    tick_st.last = ts_r;
    if (st_rd.count == '0) begin
      tick_st.count = CNT_W'(1);
    end else if (st_rd.count != {CNT_W{1'b1}}) begin
      tick_st.count = st_rd.count + CNT_W'(1);
    end
  end

  logic signed [45:0] q_s;
  logic signed [45:0] mean_sum;
  logic [MEAN_W-1:0]  mn;
  logic signed [45:0] d2;
  logic [45:0]        d2_abs;
  logic signed [45:0] sumb;
  logic [45:0]        sumb_abs;
  logic [42:0]        d_r_abs;
  logic [25:0]        a_r_abs;
  logic [MUL_W-1:0]   mag_a;
  logic [MUL_W-1:0]   mag_b;
  logic               sign_a;
  logic               sign_b;

  always_comb begin
    q_s      = $signed({5'b0, div_quot[DIV_DW-1:0]});
    mean_sum = $signed({6'b0, cur.mean}) + (neg_r ? -q_s : q_s);
    if (mean_sum < 0) begin
      mn = '0;
    end else if (mean_sum > $signed({6'b0, {MEAN_W{1'b1}}})) begin
      mn = {MEAN_W{1'b1}};
    end else begin
      mn = mean_sum[MEAN_W-1:0];
    end
    d2       = $signed({6'b0, per_r, 16'h0000}) - $signed({6'b0, mn});
    d2_abs   = d2[45] ? 46'(-d2) : 46'(d2);
    sumb     = d2 + ($signed({6'b0, old_r, 16'h0000}) - $signed({6'b0, cur.mean}));
    sumb_abs = sumb[45] ? 46'(-sumb) : 46'(sumb);
    d_r_abs  = d_r[42] ? 43'(-d_r) : 43'(d_r);
    a_r_abs  = a_r[25] ? 26'(-a_r) : 26'(a_r);
    if (full_r) begin
      mag_a  = MUL_W'(a_r_abs);
      sign_a = a_r[25];
      mag_b  = sumb_abs[41:8];
      sign_b = sumb[45] && (mag_b != '0);
    end else begin
      mag_a  = d_r_abs[41:8];
      sign_a = d_r[42] && (mag_a != '0);
      mag_b  = d2_abs[41:8];
      sign_b = d2[45] && (mag_b != '0);
    end
  end

  // saturating M2 update from the finished product
  logic [M2_W-1:0] prod_mag;
  logic [M2_W:0]   m2_add;
  logic [M2_W-1:0] m2_new;

  always_comb begin
    prod_mag = full_r ? acc[M2_W-1:0] : M2_W'(acc[2*MUL_W-1:8]);
    m2_add   = {1'b0, cur.m2} + {1'b0, prod_mag};
    if (mneg_r) begin
      m2_new = (prod_mag > cur.m2) ? '0 : cur.m2 - prod_mag;
    end else begin
      m2_new = m2_add[M2_W] ? {M2_W{1'b1}} : m2_add[M2_W-1:0];
    end
  end

  // ---------------- query arithmetic ----------------
  logic [47:0] el_scaled;
  logic [47:0] mean_lim;
  logic        timed_out;

  assign el_scaled = {el_diff, 16'h0000};
  assign mean_lim  = 48'({4'b0, st_rd.mean} * 44'(TIMEOUT_PERIODS));
  assign timed_out = (st_rd.mean != '0) && (el_scaled > mean_lim);

  logic [OUT_W-1:0] sq_t;
  logic [63:0]      sq_tsq;
  logic             sq_fit;

  // (r + 2^k)^2 = r^2 + r*2^(k+1) + 2^(2k)
  always_comb begin
    sq_t   = sq_r | (OUT_W'(1) << sq_bit);
    sq_tsq = sq_sq + ({32'h0, sq_r} << (6'(sq_bit) + 6'd1)) + (64'h1 << {sq_bit, 1'b0});
    sq_fit = {8'h00, sq_tsq} <= {var_r, 8'h00};
  end

  // ---------------- control ----------------
  logic div_start;
  logic res_load;

  assign div_start = ((state == ST_RDST) && (op_r == OP_TICK) && (st_rd.count != '0) &&
                      (st_rd.fill < w_eff)) ||
                     ((state == ST_RDST) && (op_r != OP_TICK) &&
                      (st_rd.count >= CNT_W'(2)) && !timed_out && (st_rd.mean != '0)) ||
                     (state == ST_RDRNG) ||
                     ((state == ST_QVAR) && (cur.fill > FILL_W'(1)));
  assign res_load  = (state == ST_QOUT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window        <= CFG_W'(WINDOW_MAX);
      chan_valid    <= '0;
      m_axis_tvalid <= 1'b0;
      div_go        <= 1'b0;
      ring_wr_r     <= 1'b0;
    end else begin
      div_go <= div_start;
      if (cfg_we) begin
        window <= cfg_wdata;
      end
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RDST;
          end
        end

        ST_RDST: begin
          cur <= (op_r == OP_TICK) ? tick_st : st_rd;
          if (op_r == OP_TICK) begin
            if (st_rd.count == '0) begin
              ring_wr_r <= 1'b0;
              state     <= ST_WRB;
            end else begin
              per_r     <= per_calc;
              if (st_rd.fill < w_eff) begin
                full_r  <= 1'b0;
                d_r     <= d_calc;
                neg_r   <= d_calc[42];
                div_num <= DIV_NW'(d_calc_abs);
                div_den <= DIV_DW'(st_rd.fill) + DIV_DW'(1);
                state   <= ST_DIV1;
              end else begin
                full_r  <= 1'b1;
                state   <= ST_RDRNG;
              end
            end
          end else begin
            res_count  <= st_rd.count;
            res_freq   <= '0;
            res_mean   <= '0;
            res_jit    <= '0;
            if (st_rd.count < CNT_W'(2)) begin
              res_status <= STAT_NOT_ENOUGH;
              state      <= ST_QOUT;
            end else if (timed_out) begin
              res_status <= STAT_TIMED_OUT;
              state      <= ST_QOUT;
            end else begin
              res_status <= STAT_VALID;
              res_mean   <= st_rd.mean;
              if (st_rd.mean != '0) begin
                div_num <= DIV_NW'(1) << 48;
                div_den <= DIV_DW'(st_rd.mean);
                state   <= ST_QDIVF;
              end else begin
                state   <= ST_QVAR;
              end
            end
          end
        end

        ST_RDRNG: begin
          old_r   <= ring_rdata;
          a_r     <= a_calc;
          neg_r   <= a_calc[25];
          div_num <= DIV_NW'({a_calc_abs[PER_W-1:0], 16'h0000});
          div_den <= DIV_DW'(cur.fill);
          state   <= ST_DIV1;
        end

        ST_DIV1: begin
          if (div_done) begin
            cur.mean  <= mn;
            ring_wr_r <= 1'b1;
            if (full_r) begin
              ring_waddr_r <= {ch_r, cur.head};
              cur.head     <= cur.head + WIN_W'(1);
            end else begin
              ring_waddr_r <= {ch_r, cur.head + cur.fill[WIN_W-1:0]};
              cur.fill     <= cur.fill + FILL_W'(1);
            end
            mul_a   <= (2*MUL_W)'(mag_a);
            mul_b   <= mag_b;
            acc     <= '0;
            mul_cnt <= '0;
            mneg_r  <= sign_a ^ sign_b;
            state   <= ST_MUL;
          end
        end

        ST_MUL: begin
          if (mul_cnt == MUL_CW'(MUL_W)) begin
            cur.m2 <= m2_new;
            state  <= ST_WRB;
          end else begin
            if (mul_b[0]) begin
              acc <= acc + mul_a;
            end
            mul_a   <= mul_a << 1;
            mul_b   <= mul_b >> 1;
            mul_cnt <= mul_cnt + MUL_CW'(1);
          end
        end

        ST_WRB: begin
          chan_valid[ch_r] <= 1'b1;
          state            <= ST_IDLE;
        end

        ST_QDIVF: begin
          if (div_done) begin
            res_freq <= (div_quot[DIV_NW-1:OUT_W] != '0) ? {OUT_W{1'b1}}
                                                         : div_quot[OUT_W-1:0];
            state    <= ST_QVAR;
          end
        end

        ST_QVAR: begin
          if (cur.fill > FILL_W'(1)) begin
            div_num <= cur.m2;
            div_den <= DIV_DW'(cur.fill) - DIV_DW'(1);
            state   <= ST_QDIVV;
          end else begin
            state   <= ST_QOUT;
          end
        end

        ST_QDIVV: begin
          if (div_done) begin
            var_r  <= div_quot;
            sq_r   <= '0;
            sq_sq  <= '0;
            sq_bit <= 5'd31;
            state  <= ST_QSQRT;
          end
        end

        ST_QSQRT: begin
          if (sq_fit) begin
            sq_r  <= sq_t;
            sq_sq <= sq_tsq;
          end
          if (sq_bit == 5'd0) begin
            res_jit <= sq_fit ? sq_t : sq_r;
            state   <= ST_QOUT;
          end else begin
            sq_bit <= sq_bit - 5'd1;
          end
        end

        ST_QOUT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= s_axis_tuser;
      ch_r <= s_axis_tdata[CH_W-1:0];
      ts_r <= s_axis_tdata[CH_W+TS_W-1:CH_W];
    end
    if (res_load) begin
      m_axis_tdata <= {res_jit, res_mean, res_freq, res_count};
      m_axis_tuser <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV1 || state == ST_QDIVF || state == ST_QDIVV))
    else $error("divider finished with no consumer waiting");

  a_wb_marks_valid: assert property (@(posedge clk) disable iff (rst)
    st_we |=> chan_valid[$past(ch_r)])
    else $error("written channel not marked valid");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    st_we |-> (cur.fill <= FILL_W'(WINDOW_MAX)))
    else $error("fill level beyond ring depth");

  a_result_from_qout: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_QOUT))
    else $error("result raised outside the output state");

  a_ring_write_tick_only: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> (op_r == OP_TICK))
    else $error("ring written by a query");
`endif

endmodule

`default_nettype wire

FILE: rtl/erjm_ram.sv
// erjm_ram: generic simple dual-port ram, one write port, registered read
// no dependencies
`default_nettype none

module erjm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/erjm_div.sv
// erjm_div: radix-2 restoring divider, one quotient bit per cycle
// depends on erjm_pkg
`default_nettype none

module erjm_div import erjm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic                   done,
  output logic      [DIV_NW-1:0] quot
);

  localparam int STEP_W = $clog2(DIV_NW);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_NW-1:0] qr;

  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] diff;
  logic              ge;

  assign shifted = {rem, qr[DIV_NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign ge      = !diff[DIV_DW+1];
  assign quot    = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == STEP_W'(DIV_NW - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      qr    <= num;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      qr  <= {qr[DIV_NW-2:0], ge};
    end
  end

endmodule

`default_nettype wire
